// ===== sv/lcdt_pkg.sv =====
// lcdt_pkg: shared types and constants for the lcd mode timing and register core
// holds mode and item kind codes, register offsets and dot/line timing limits
// no dependencies
`default_nettype none

package lcdt_pkg;

	// display modes as reported in the status register
	typedef enum logic [1:0] {
		MODE_HBLANK = 2'd0,
		MODE_VBLANK = 2'd1,
		MODE_OAM    = 2'd2,
		MODE_DRAW   = 2'd3
	} mode_t;

	// item kinds on the input channel
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	// register offsets above base 0x40
	localparam logic [3:0] OFF_CONTROL = 4'h0;
	localparam logic [3:0] OFF_STATUS  = 4'h1;
	localparam logic [3:0] OFF_SCY     = 4'h2;
	localparam logic [3:0] OFF_SCX     = 4'h3;
	localparam logic [3:0] OFF_LINE    = 4'h4;
	localparam logic [3:0] OFF_LYC     = 4'h5;
	localparam logic [3:0] OFF_DMA     = 4'h6;
	localparam logic [3:0] OFF_BGP     = 4'h7;
	localparam logic [3:0] OFF_OBP0    = 4'h8;
	localparam logic [3:0] OFF_OBP1    = 4'h9;
	localparam logic [3:0] OFF_WY      = 4'hA;
	localparam logic [3:0] OFF_WX      = 4'hB;
	localparam logic [3:0] OFF_BANK    = 4'hF;

	// dot and line limits
	localparam int DOT_W  = 9;
	localparam int LINE_W = 8;
	localparam logic [DOT_W-1:0]  OAM_DOTS    = 9'd80;
	localparam logic [DOT_W-1:0]  DRAW_DOTS   = 9'd172;
	localparam logic [DOT_W-1:0]  HBLANK_DOTS = 9'd204;
	localparam logic [DOT_W-1:0]  LINE_DOTS   = 9'd456;
	localparam logic [DOT_W-1:0]  DOT_STEP    = 9'd2;
	localparam logic [LINE_W-1:0] VBLANK_LINE = 8'd144;
	localparam logic [LINE_W-1:0] LINES_TOTAL = 8'd154;

	// reset value of every palette
	localparam logic [7:0] PALETTE_RESET = 8'hE4;

	// status enable bit positions
	localparam int EN_MODE0 = 0;
	localparam int EN_MODE2 = 2;
	localparam int EN_LYC   = 3;

endpackage

`default_nettype wire

// ===== sv/lcd_mode_timing_registers_core.sv =====
// lcd_mode_timing_registers_core: lcd dot/line timing, interrupt requests and register file
// depends on lcdt_pkg for mode and kind codes, register offsets and timing limits
`default_nettype none

//  channel | signals                                            | transfer when
//  --------+----------------------------------------------------+---------------------
//  in      | in_valid, in_stall, kind, reg_offset, write_data   | in_valid & !in_stall
//  out     | out_valid, out_stall, read_data, vblank_irq,       | out_valid & !out_stall
//          | stat_irq, mode_now, line_now                       |
//
// one item per clock while the output does not stall; an item passes an input register
// then the result register, with state updated as an item leaves the input register
// reset clears all timing state, enables and registers; palettes come up as 0xE4
// a stall on the output holds the result register, then the input register,
// and only then raises in_stall

module lcd_mode_timing_registers_core
	import lcdt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [3:0]        reg_offset,
	input  wire logic [7:0]        write_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [7:0]             read_data,
	output logic                   vblank_irq,
	output logic                   stat_irq,
	output logic [1:0]             mode_now,
	output logic [LINE_W-1:0]      line_now
);

	// input stage
	logic              valid_s1;
	kind_t             kind_s1;
	logic [3:0]        off_s1;
	logic [7:0]        data_s1;

	// result stage
	logic              valid_s2;
	logic [7:0]        rd_s2;
	logic              vbl_s2;
	logic              stat_s2;
	mode_t             mode_s2;
	logic [LINE_W-1:0] line_s2;

	// timing state and register file
	mode_t             mode_q;
	logic [LINE_W-1:0] line_q;
	logic [DOT_W-1:0]  dot_q;
	logic [7:0]        control_q;
	logic [3:0]        stat_en_q;
	logic [7:0]        scy_q;
	logic [7:0]        scx_q;
	logic [7:0]        lyc_q;
	logic [7:0]        pal_q [3];
	logic [7:0]        win_q [2];
	logic              bank_q;

	// next values
	mode_t             mode_nxt;
	logic [LINE_W-1:0] line_nxt;
	logic [DOT_W-1:0]  dot_nxt;
	logic              vbl_nxt;
	logic              stat_nxt;
	logic [7:0]        rd_nxt;
	logic [LINE_W-1:0] line_inc;
	logic [DOT_W-1:0]  dot_inc;

	logic s2_take;
	logic s1_take;
	logic advance;

	// handshake: result register frees up when empty or taken
	assign s2_take  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_take;
	assign in_stall = valid_s1 && !s2_take;
	assign s1_take  = in_valid && !in_stall;

	assign line_inc = LINE_W'(line_q + 8'd1);
	assign dot_inc  = DOT_W'(dot_q + DOT_STEP);

	// timing tick
	always_comb begin
		mode_nxt = mode_q;
		line_nxt = line_q;
		dot_nxt  = dot_q;
		vbl_nxt  = 1'b0;
		stat_nxt = 1'b0;
		if (kind_s1 == KIND_TICK) begin
			unique case (mode_q)
				MODE_HBLANK: begin
					if (dot_q >= HBLANK_DOTS) begin
						dot_nxt  = '0;
						line_nxt = line_inc;
						if (stat_en_q[EN_LYC] && lyc_q == line_inc)
							stat_nxt = 1'b1;
						if (line_inc == VBLANK_LINE) begin
							mode_nxt = MODE_VBLANK;
							vbl_nxt  = 1'b1;
						end else begin
							mode_nxt = MODE_OAM;
							if (stat_en_q[EN_MODE2])
								stat_nxt = 1'b1;
						end
					end else begin
						dot_nxt = dot_inc;
					end
				end
				MODE_VBLANK: begin
					if (dot_q >= LINE_DOTS) begin
						dot_nxt = '0;
						if (line_inc >= LINES_TOTAL) begin
							mode_nxt = MODE_OAM;
							line_nxt = '0;
							if (stat_en_q[EN_MODE2] || (stat_en_q[EN_LYC] && lyc_q == 8'd0))
								stat_nxt = 1'b1;
						end else begin
							line_nxt = line_inc;
							if (stat_en_q[EN_LYC] && lyc_q == line_inc)
								stat_nxt = 1'b1;
						end
					end else begin
						dot_nxt = dot_inc;
					end
				end
				MODE_OAM: begin
					if (dot_q >= OAM_DOTS) begin
						dot_nxt  = '0;
						mode_nxt = MODE_DRAW;
					end else begin
						dot_nxt = dot_inc;
					end
				end
				MODE_DRAW: begin
					if (dot_q >= DRAW_DOTS) begin
						dot_nxt  = '0;
						mode_nxt = MODE_HBLANK;
						if (stat_en_q[EN_MODE0])
							stat_nxt = 1'b1;
					end else begin
						dot_nxt = dot_inc;
					end
				end
				default: begin
					mode_nxt = mode_q;
				end
			endcase
		end
	end

	// register read decoder
	always_comb begin
		rd_nxt = '0;
		if (kind_s1 == KIND_READ) begin
			unique case (off_s1)
				OFF_CONTROL: rd_nxt = control_q;
				OFF_STATUS:  rd_nxt = {1'b0, stat_en_q, (line_q == lyc_q), mode_q};
				OFF_SCY:     rd_nxt = scy_q;
				OFF_SCX:     rd_nxt = scx_q;
				OFF_LINE:    rd_nxt = line_q;
				OFF_LYC:     rd_nxt = lyc_q;
				OFF_BGP:     rd_nxt = pal_q[0];
				OFF_OBP0:    rd_nxt = pal_q[1];
				OFF_OBP1:    rd_nxt = pal_q[2];
				OFF_WY:      rd_nxt = win_q[0];
				OFF_WX:      rd_nxt = win_q[1];
				OFF_BANK:    rd_nxt = {7'd0, bank_q};
				default:     rd_nxt = '0;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			kind_s1 <= kind_t'(kind);
			off_s1  <= reg_offset;
			data_s1 <= write_data;
		end
	end

	// timing state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HBLANK;
			line_q <= '0;
			dot_q  <= '0;
		end else if (advance) begin
			mode_q <= mode_nxt;
			line_q <= line_nxt;
			dot_q  <= dot_nxt;
		end
	end

	// register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q <= '0;
			stat_en_q <= '0;
			scy_q     <= '0;
			scx_q     <= '0;
			lyc_q     <= '0;
			pal_q[0]  <= PALETTE_RESET;
			pal_q[1]  <= PALETTE_RESET;
			pal_q[2]  <= PALETTE_RESET;
			win_q[0]  <= '0;
			win_q[1]  <= '0;
			bank_q    <= 1'b0;
		end else if (advance && kind_s1 == KIND_WRITE) begin
			unique case (off_s1)
				OFF_CONTROL: control_q <= data_s1;
				OFF_STATUS:  stat_en_q <= data_s1[6:3];
				OFF_SCY:     scy_q     <= data_s1;
				OFF_SCX:     scx_q     <= data_s1;
				OFF_LYC:     lyc_q     <= data_s1;
				OFF_BGP:     pal_q[0]  <= data_s1;
				OFF_OBP0:    pal_q[1]  <= data_s1;
				OFF_OBP1:    pal_q[2]  <= data_s1;
				OFF_WY:      win_q[0]  <= data_s1;
				OFF_WX:      win_q[1]  <= data_s1;
				OFF_BANK:    bank_q    <= (data_s1 != 8'd0);
				default:     bank_q    <= bank_q;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_s2   <= rd_nxt;
			vbl_s2  <= vbl_nxt;
			stat_s2 <= stat_nxt;
			mode_s2 <= mode_nxt;
			line_s2 <= line_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign read_data  = rd_s2;
	assign vblank_irq = vbl_s2;
	assign stat_irq   = stat_s2;
	assign mode_now   = mode_s2;
	assign line_now   = line_s2;

	// line counter stays within the frame
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_q < LINES_TOTAL)
		else $error("line counter out of frame");

	// vblank mode exactly covers the lines from 144 upward
	a_vblank_lines: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_VBLANK) == (line_q >= VBLANK_LINE))
		else $error("mode and line disagree on vblank");

	// a vblank request reports the first vblank line
	a_vbl_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && vblank_irq) |-> (mode_now == MODE_VBLANK && line_now == VBLANK_LINE))
		else $error("vblank request away from line 144");

	// requests never ride along with read data
	a_irq_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (vblank_irq || stat_irq)) |-> (read_data == 8'd0))
		else $error("request on a register access");

	// dot counter never runs past a vblank line
	a_dot_range: assert property (@(posedge clk) disable iff (!arst_n)
		dot_q <= LINE_DOTS)
		else $error("dot counter overran");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for lcd_mode_timing_registers_core, one transfer in and one out per item
// carries its own model of the dot/line timing, request logic and register file
// depends on lcdt_pkg and the core

module tb;
	import lcdt_pkg::*;

	typedef struct packed {
		kind_t      k;
		logic [3:0] off;
		logic [7:0] data;
	} lcd_item_t;

	typedef struct packed {
		logic [7:0]        rd;
		logic              vbl;
		logic              stat;
		mode_t             mode;
		logic [LINE_W-1:0] line;
	} lcd_result_t;

	localparam int MIXED_ITEMS = 400;
	localparam int FRAME_ITEMS = 576;
	localparam int CALM_FIRST  = 500;
	localparam int CALM_LAST   = 800;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 64;
	localparam int MAX_SHOWN   = 10;
	localparam int IDLE_PCT    = 7;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [1:0]        kind;
	logic [3:0]        reg_offset;
	logic [7:0]        write_data;
	logic              out_valid;
	logic              out_stall;
	logic [7:0]        read_data;
	logic              vblank_irq;
	logic              stat_irq;
	logic [1:0]        mode_now;
	logic [LINE_W-1:0] line_now;

	lcd_mode_timing_registers_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.reg_offset (reg_offset),
		.write_data (write_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.vblank_irq (vblank_irq),
		.stat_irq   (stat_irq),
		.mode_now   (mode_now),
		.line_now   (line_now)
	);

	// clock, 10 ns period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// model of the display timing and register file
	mode_t             lcd_mode;
	logic [LINE_W-1:0] lcd_line;
	logic [DOT_W-1:0]  lcd_dot;
	logic [7:0]        lcd_ctrl;
	logic [3:0]        lcd_enables;
	logic [7:0]        lcd_scy;
	logic [7:0]        lcd_scx;
	logic [7:0]        lcd_lyc;
	logic [7:0]        lcd_pal [0:2];
	logic [7:0]        lcd_win [0:1];
	logic              lcd_bank;

	lcd_item_t   pending_q [$];
	lcd_result_t expected_q [$];

	int  sent_cnt = 0;
	int  got_cnt = 0;
	int  err_cnt = 0;
	int  tick_cnt = 0;
	int  write_cnt = 0;
	int  read_cnt = 0;
	int  other_cnt = 0;
	int  vbl_seen = 0;
	int  stat_seen = 0;
	int  cycle_cnt = 0;
	int  cycle_limit = 32'h7fffffff;
	int  hold_left = 0;
	bit  hold_done = 1'b0;
	bit  in_done = 1'b0;
	lcd_item_t   nxt_item;
	lcd_item_t   taken_item;
	lcd_result_t want;
	lcd_result_t next_want;

	// one item through the model: timing tick, register write or register read
	task automatic lcd_step(input lcd_item_t it, output lcd_result_t r);
		r = '0;
		case (it.k)
			KIND_TICK: begin
				case (lcd_mode)
					MODE_HBLANK: begin
						if (lcd_dot >= HBLANK_DOTS) begin
							lcd_dot = '0;
							lcd_line = lcd_line + 1'b1;
							if (lcd_enables[EN_LYC] && lcd_lyc == lcd_line)
								r.stat = 1'b1;
							if (lcd_line == VBLANK_LINE) begin
								lcd_mode = MODE_VBLANK;
								r.vbl = 1'b1;
							end else begin
								lcd_mode = MODE_OAM;
								if (lcd_enables[EN_MODE2])
									r.stat = 1'b1;
							end
						end else begin
							lcd_dot = lcd_dot + DOT_STEP;
						end
					end
					MODE_VBLANK: begin
						if (lcd_dot >= LINE_DOTS) begin
							lcd_dot = '0;
							lcd_line = lcd_line + 1'b1;
							// wrap back to line 0 and oam scan
							if (lcd_line >= LINES_TOTAL) begin
								lcd_mode = MODE_OAM;
								lcd_line = '0;
								if (lcd_enables[EN_MODE2])
									r.stat = 1'b1;
							end
							if (lcd_enables[EN_LYC] && lcd_lyc == lcd_line)
								r.stat = 1'b1;
						end else begin
							lcd_dot = lcd_dot + DOT_STEP;
						end
					end
					MODE_OAM: begin
						if (lcd_dot >= OAM_DOTS) begin
							lcd_dot = '0;
							lcd_mode = MODE_DRAW;
						end else begin
							lcd_dot = lcd_dot + DOT_STEP;
						end
					end
					default: begin
						if (lcd_dot >= DRAW_DOTS) begin
							lcd_dot = '0;
							lcd_mode = MODE_HBLANK;
							if (lcd_enables[EN_MODE0])
								r.stat = 1'b1;
						end else begin
							lcd_dot = lcd_dot + DOT_STEP;
						end
					end
				endcase
			end
			KIND_WRITE: begin
				case (it.off)
					OFF_CONTROL: lcd_ctrl = it.data;
					OFF_STATUS:  lcd_enables = it.data[6:3];
					OFF_SCY:     lcd_scy = it.data;
					OFF_SCX:     lcd_scx = it.data;
					OFF_LYC:     lcd_lyc = it.data;
					OFF_BGP:     lcd_pal[0] = it.data;
					OFF_OBP0:    lcd_pal[1] = it.data;
					OFF_OBP1:    lcd_pal[2] = it.data;
					OFF_WY:      lcd_win[0] = it.data;
					OFF_WX:      lcd_win[1] = it.data;
					OFF_BANK:    lcd_bank = |it.data;
					default: ;
				endcase
			end
			KIND_READ: begin
				case (it.off)
					OFF_CONTROL: r.rd = lcd_ctrl;
					OFF_STATUS:  r.rd = {1'b0, lcd_enables, lcd_line == lcd_lyc, lcd_mode};
					OFF_SCY:     r.rd = lcd_scy;
					OFF_SCX:     r.rd = lcd_scx;
					OFF_LINE:    r.rd = lcd_line;
					OFF_LYC:     r.rd = lcd_lyc;
					OFF_BGP:     r.rd = lcd_pal[0];
					OFF_OBP0:    r.rd = lcd_pal[1];
					OFF_OBP1:    r.rd = lcd_pal[2];
					OFF_WY:      r.rd = lcd_win[0];
					OFF_WX:      r.rd = lcd_win[1];
					OFF_BANK:    r.rd = {7'd0, lcd_bank};
					default:     r.rd = 8'h00;
				endcase
			end
			default: ;
		endcase
		r.mode = lcd_mode;
		r.line = lcd_line;
	endtask

	task automatic queue_item(input kind_t k, input logic [3:0] off, input logic [7:0] d);
		lcd_item_t it;
		it.k = k;
		it.off = off;
		it.data = d;
		pending_q.push_back(it);
	endtask

	// random register access; line compare writes kept in a range the line counter reaches
	function automatic lcd_item_t random_access(input int lyc_max);
		lcd_item_t it;
		int pick;
		pick = $urandom_range(19);
		if (pick < 9)
			it.k = KIND_WRITE;
		else if (pick < 18)
			it.k = KIND_READ;
		else
			it.k = KIND_NONE;
		it.off = 4'($urandom_range(15));
		it.data = 8'($urandom_range(255));
		if (it.k == KIND_WRITE && it.off == OFF_LYC)
			it.data = 8'($urandom_range(lyc_max));
		return it;
	endfunction

	// input driver: new payload only after a transfer or while valid is low
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_done) begin
			in_valid <= 1'b1;
		end else if (pending_q.size() > 0 &&
				((sent_cnt >= CALM_FIRST && sent_cnt < CALM_LAST) ||
				$urandom_range(99) >= IDLE_PCT)) begin
			nxt_item = pending_q.pop_front();
			kind <= nxt_item.k;
			reg_offset <= nxt_item.off;
			write_data <= nxt_item.data;
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// output back-pressure, with one long hold so the core fills and stalls its input
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else if (!hold_done && got_cnt >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			out_stall <= 1'b1;
		end else if (got_cnt >= CALM_FIRST && got_cnt < CALM_LAST) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	// result check first, then the model takes the input transfer of this edge
	always @(posedge clk) begin
		in_done = arst_n && in_valid && !in_stall;
		if (arst_n && out_valid && !out_stall) begin
			got_cnt = got_cnt + 1;
			vbl_seen = vbl_seen + vblank_irq;
			stat_seen = stat_seen + stat_irq;
			if (expected_q.size() == 0) begin
				err_cnt = err_cnt + 1;
				if (err_cnt <= MAX_SHOWN)
					$display("%0t: result transfer %0d arrived with nothing expected",
						$realtime, got_cnt);
			end else begin
				want = expected_q.pop_front();
				if (read_data !== want.rd || vblank_irq !== want.vbl ||
						stat_irq !== want.stat || mode_now !== want.mode ||
						line_now !== want.line) begin
					err_cnt = err_cnt + 1;
					if (err_cnt <= MAX_SHOWN)
						$display({"%0t: result %0d exp rd=%h vbl=%b stat=%b mode=%0d line=%0d",
							" got rd=%h vbl=%b stat=%b mode=%0d line=%0d"},
							$realtime, got_cnt, want.rd, want.vbl, want.stat, want.mode,
							want.line, read_data, vblank_irq, stat_irq, mode_now, line_now);
				end
			end
		end
		if (in_done) begin
			taken_item.k = kind_t'(kind);
			taken_item.off = reg_offset;
			taken_item.data = write_data;
			case (taken_item.k)
				KIND_TICK:  tick_cnt = tick_cnt + 1;
				KIND_WRITE: write_cnt = write_cnt + 1;
				KIND_READ:  read_cnt = read_cnt + 1;
				default:    other_cnt = other_cnt + 1;
			endcase
			lcd_step(taken_item, next_want);
			expected_q.push_back(next_want);
			sent_cnt = sent_cnt + 1;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt = cycle_cnt + 1;
		if (cycle_cnt > cycle_limit) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycle_cnt, expected_q.size());
			$display("lcd_mode_timing_registers_core: mismatch");
			$finish;
		end
	end

	initial begin
		lcd_item_t it;
		int i;

		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		reg_offset = 4'h0;
		write_data = 8'h00;
		out_stall = 1'b0;

		// model state after reset
		lcd_mode = MODE_HBLANK;
		lcd_line = '0;
		lcd_dot = '0;
		lcd_ctrl = 8'h00;
		lcd_enables = 4'h0;
		lcd_scy = 8'h00;
		lcd_scx = 8'h00;
		lcd_lyc = 8'h00;
		for (i = 0; i < 3; i++)
			lcd_pal[i] = PALETTE_RESET;
		lcd_win[0] = 8'h00;
		lcd_win[1] = 8'h00;
		lcd_bank = 1'b0;

		// directed: reset values, extremes, ignored writes, unused kind, bank on and off
		queue_item(KIND_READ, OFF_BGP, 8'h00);
		queue_item(KIND_READ, OFF_OBP1, 8'hFF);
		queue_item(KIND_READ, OFF_STATUS, 8'h00);
		queue_item(KIND_WRITE, OFF_CONTROL, 8'hFF);
		queue_item(KIND_WRITE, OFF_STATUS, 8'hFF);
		queue_item(KIND_WRITE, OFF_LINE, 8'h5A);
		queue_item(KIND_WRITE, OFF_DMA, 8'hFF);
		queue_item(KIND_WRITE, 4'hC, 8'hFF);
		queue_item(KIND_WRITE, OFF_OBP0, 8'h00);
		queue_item(KIND_WRITE, OFF_BANK, 8'h80);
		queue_item(KIND_NONE, 4'hF, 8'hFF);
		queue_item(KIND_READ, OFF_CONTROL, 8'h00);
		queue_item(KIND_READ, OFF_STATUS, 8'h00);
		queue_item(KIND_READ, OFF_LINE, 8'h00);
		queue_item(KIND_READ, OFF_DMA, 8'h00);
		queue_item(KIND_READ, OFF_OBP0, 8'h00);
		queue_item(KIND_READ, 4'hC, 8'h00);
		queue_item(KIND_READ, OFF_BANK, 8'h00);
		queue_item(KIND_TICK, 4'hF, 8'hFF);
		queue_item(KIND_TICK, 4'h0, 8'h00);
		queue_item(KIND_WRITE, OFF_BANK, 8'h00);
		queue_item(KIND_WRITE, OFF_STATUS, 8'h00);
		queue_item(KIND_READ, OFF_BANK, 8'h00);
		queue_item(KIND_READ, OFF_STATUS, 8'h00);

		// mixed accesses and ticks over the first lines
		for (i = 0; i < MIXED_ITEMS; i++) begin
			it = random_access(3);
			if ($urandom_range(99) < 55)
				it.k = KIND_TICK;
			pending_q.push_back(it);
		end

		// mostly ticks: several more lines with sparse register traffic
		for (i = 0; i < FRAME_ITEMS; i++) begin
			it = random_access(5);
			if ($urandom_range(99) < 98)
				it.k = KIND_TICK;
			pending_q.push_back(it);
		end

		cycle_limit = 20 * pending_q.size() + 20000;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// drain: all items taken, all results back, then a wait for strays
		while (pending_q.size() != 0 || in_valid) @(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("ran %0d ticks, %0d writes, %0d reads and %0d unused-kind items; %0d results",
			tick_cnt, write_cnt, read_cnt, other_cnt, got_cnt);
		$display("saw %0d vblank and %0d status requests, %0d mismatching results",
			vbl_seen, stat_seen, err_cnt);
		if (err_cnt == 0)
			$display("lcd_mode_timing_registers_core: match");
		else
			$display("lcd_mode_timing_registers_core: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/lcdt_pkg.sv
sv/lcd_mode_timing_registers_core.sv
bench/tb.sv
